// ----- rtl/core/kfsi_pkg.sv -----
// kfsi_pkg: shared constants and codes for the keyframe sampler/interpolator
// depends on nothing; used by keyframe_sampler_interpolator_top
`timescale 1ns / 1ps
`default_nettype none
package kfsi_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int KEY_W          = 8;
  localparam int MAX_KEYS       = 256;
  localparam int COMP_W         = 2;
  localparam int MAX_COMPONENTS = 4;
  localparam int SLOT_W         = 2;
  localparam int VADDR_W        = KEY_W + SLOT_W + COMP_W;
  localparam int VDEPTH         = 1 << VADDR_W;

  // request codes
  localparam logic [1:0] REQ_LOAD_TIME  = 2'd0;
  localparam logic [1:0] REQ_LOAD_VALUE = 2'd1;
  localparam logic [1:0] REQ_SAMPLE     = 2'd2;

  // slot codes
  localparam logic [1:0] SLOT_IN   = 2'd0;
  localparam logic [1:0] SLOT_VAL  = 2'd1;
  localparam logic [1:0] SLOT_OUT  = 2'd2;
  localparam logic [1:0] SLOT_NONE = 2'd3;

  // interpolation modes
  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INTERP_MODE     = 2'd0;
  localparam logic [1:0] CFG_KEY_COUNT       = 2'd1;
  localparam logic [1:0] CFG_COMPONENT_COUNT = 2'd2;

  // 1.0 in fixed point
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

endpackage
`default_nettype wire

// ----- rtl/core/keyframe_sampler_interpolator_top.sv -----
// keyframe_sampler_interpolator_top: keyframe table, search and interpolation
// depends on kfsi_pkg and kfsi_ram
`timescale 1ns / 1ps
`default_nettype none

// Load items (key time or one value word) are written on acceptance and keep
// in_ready high. A sample item runs on one sequencer around a single shared
// 34x34 multiplier and a 33-bit subtract/compare: it tests the end keys, runs
// the upper-bound search (up to 9 steps), fetches the segment, finds the
// segment fraction by a 16-bit restoring division, forms the Hermite basis
// and tangent weights in cubic mode, then adds the value terms (1 term for
// step or clamped samples, 2 linear, 4 cubic) and writes one result per
// component (a single one on a segment error). in_ready is low while a
// sample is in work; the last result waits in the output register while the
// next item enters.
// The value store is a 4096-word RAM addressed by key, slot and component.
module keyframe_sampler_interpolator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  key_index,
  input  wire logic [1:0]  slot,
  input  wire logic [1:0]  component,
  input  wire logic [31:0] load_word,
  input  wire logic [31:0] query_time,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       comp_index,
  output logic signed [31:0] sample_value,
  output logic             last,
  output logic             status
);

  localparam int F  = kfsi_pkg::FRAC_BITS;
  localparam int KW = kfsi_pkg::KEY_W;
  localparam int UW = kfsi_pkg::FRAC_BITS + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T0W, S_TLW, S_SP, S_SW, S_NA, S_NW, S_PW, S_DIV,
    S_M2, S_M2R, S_M3, S_M3R, S_H, S_MW0, S_MW0R, S_MW1, S_MW1R,
    S_VA, S_VM, S_VS, S_OUT
  } state_t;

  typedef enum logic [1:0] {K_ONE, K_LIN, K_CUB} kind_t;

  state_t state;
  kind_t  kind;

  // configuration registers
  logic [1:0] interp_mode;
  logic [8:0] key_count;
  logic [2:0] component_count;

  // per-sample registers
  logic [31:0] qt;
  logic [8:0]  n;
  logic [2:0]  cc;
  logic [1:0]  mode;
  logic [8:0]  first;
  logic [8:0]  count;
  logic [KW-1:0] prev;
  logic [KW-1:0] next;
  logic [1:0]  vslot;
  logic [31:0] tn;
  logic [31:0] d;
  logic [31:0] rem;
  logic [3:0]  dcnt;
  logic [UW-1:0] u;
  logic [UW-1:0] u2;
  logic [UW-1:0] u3;
  logic signed [19:0] h00, h10, h01, h11;
  logic signed [31:0] w10, w11;
  logic [1:0]  k;
  logic [1:0]  klast;
  logic [1:0]  c;
  logic signed [63:0] acc;
  logic        err;
  logic signed [67:0] prod;

  // memories
  logic          t_we;
  logic [KW-1:0] t_addr;
  logic [31:0]   t_rdata;
  logic          v_we;
  logic [kfsi_pkg::VADDR_W-1:0] v_addr;
  logic [31:0]   v_rdata;

  kfsi_ram #(.WIDTH(32), .DEPTH(kfsi_pkg::MAX_KEYS)) u_times (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(load_word), .rdata(t_rdata)
  );

  kfsi_ram #(.WIDTH(32), .DEPTH(kfsi_pkg::VDEPTH)) u_values (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(load_word), .rdata(v_rdata)
  );

  logic accept;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // search probe and divider step
  logic [8:0]  step;
  logic [8:0]  probe;
  logic [32:0] rem2;
  logic        div_ge;
  assign step   = count >> 1;
  assign probe  = first + step;
  assign rem2   = {rem, 1'b0};
  assign div_ge = rem2 >= {1'b0, d};

  // value term address select
  logic [KW-1:0] term_key;
  logic [1:0]    term_slot;
  always_comb begin
    term_key  = prev;
    term_slot = vslot;
    case (kind)
      K_LIN: begin
        term_key  = (k == 2'd0) ? prev : next;
        term_slot = kfsi_pkg::SLOT_IN;
      end
      K_CUB: begin
        term_key = (k < 2'd2) ? prev : next;
        case (k)
          2'd0:    term_slot = kfsi_pkg::SLOT_VAL;
          2'd1:    term_slot = kfsi_pkg::SLOT_OUT;
          2'd2:    term_slot = kfsi_pkg::SLOT_VAL;
          default: term_slot = kfsi_pkg::SLOT_IN;
        endcase
      end
      default: ;
    endcase
  end

  // term weight
  logic signed [33:0] weight;
  always_comb begin
    weight = 34'(kfsi_pkg::ONE);
    case (kind)
      K_LIN: weight = (k == 2'd0) ? 34'(kfsi_pkg::ONE - u) : 34'(u);
      K_CUB: begin
        case (k)
          2'd0:    weight = 34'(h00);
          2'd1:    weight = 34'(w10);
          2'd2:    weight = 34'(h01);
          default: weight = 34'(w11);
        endcase
      end
      default: ;
    endcase
  end

  // memory ports
  always_comb begin
    t_we   = accept && (req_type == kfsi_pkg::REQ_LOAD_TIME);
    t_addr = key_index;
    case (state)
      S_T0:    t_addr = '0;
      S_T0W:   t_addr = KW'(n - 9'd1);
      S_SP:    t_addr = probe[KW-1:0];
      S_NA:    t_addr = next;
      S_NW:    t_addr = prev;
      default: ;
    endcase
    v_we   = accept && (req_type == kfsi_pkg::REQ_LOAD_VALUE) &&
             (slot != kfsi_pkg::SLOT_NONE);
    v_addr = (state == S_VA) ? {term_key, term_slot, c} : {key_index, slot, component};
  end

  // shared multiplier operands
  logic signed [33:0] op_a;
  logic signed [33:0] op_b;
  always_comb begin
    op_a = 34'(u);
    op_b = 34'(u);
    case (state)
      S_M3:  op_a = 34'(u2);
      S_MW0: begin
        op_a = 34'(h10);
        op_b = 34'(d);
      end
      S_MW1: begin
        op_a = 34'(h11);
        op_b = 34'(d);
      end
      S_VM: begin
        op_a = 34'($signed(v_rdata));
        op_b = weight;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // tangent weight: floor shift and hold to +-2^30
  function automatic logic signed [31:0] sat_w(input logic signed [67:0] p);
    logic signed [67:0] s;
    s = p >>> kfsi_pkg::FRAC_BITS;
    if (s > 68'sd1073741824) begin
      sat_w = 32'sd1073741824;
    end else if (s < -68'sd1073741824) begin
      sat_w = -32'sd1073741824;
    end else begin
      sat_w = s[31:0];
    end
  endfunction

  // final shift and saturation of the accumulated value
  logic signed [63:0] acc_s;
  logic signed [31:0] res_val;
  always_comb begin
    acc_s = acc >>> F;
    if (acc_s > 64'sd2147483647) begin
      res_val = 32'sh7fffffff;
    end else if (acc_s < -64'sd2147483648) begin
      res_val = 32'sh80000000;
    end else begin
      res_val = acc_s[31:0];
    end
  end

  // hermite basis from u, u2, u3
  logic signed [19:0] eu, eu2, eu3, eone;
  assign eu   = 20'(u);
  assign eu2  = 20'(u2);
  assign eu3  = 20'(u3);
  assign eone = 20'(kfsi_pkg::ONE);

  logic [31:0] num;
  assign num = (qt > t_rdata) ? (qt - t_rdata) : 32'd0;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      interp_mode     <= kfsi_pkg::MODE_LINEAR;
      key_count       <= 9'd1;
      component_count <= 3'd3;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          kfsi_pkg::CFG_INTERP_MODE:     interp_mode     <= cfg_data[1:0];
          kfsi_pkg::CFG_KEY_COUNT:       key_count       <= cfg_data;
          kfsi_pkg::CFG_COMPONENT_COUNT: component_count <= cfg_data[2:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept && req_type == kfsi_pkg::REQ_SAMPLE) begin
            qt <= query_time;
            if (key_count == 9'd0) begin
              n <= 9'd1;
            end else if (key_count > 9'(kfsi_pkg::MAX_KEYS)) begin
              n <= 9'(kfsi_pkg::MAX_KEYS);
            end else begin
              n <= key_count;
            end
            if (component_count == 3'd0) begin
              cc <= 3'd1;
            end else if (component_count > 3'(kfsi_pkg::MAX_COMPONENTS)) begin
              cc <= 3'(kfsi_pkg::MAX_COMPONENTS);
            end else begin
              cc <= component_count;
            end
            mode  <= (interp_mode == 2'd3) ? kfsi_pkg::MODE_LINEAR : interp_mode;
            vslot <= (interp_mode == kfsi_pkg::MODE_CUBIC) ? kfsi_pkg::SLOT_VAL
                                                           : kfsi_pkg::SLOT_IN;
            err   <= 1'b0;
            state <= S_T0;
          end
        end
        S_T0: state <= S_T0W;
        S_T0W: begin
          if (n == 9'd1 || qt <= t_rdata) begin
            prev  <= '0;
            kind  <= K_ONE;
            klast <= 2'd0;
            c     <= '0;
            k     <= '0;
            acc   <= '0;
            state <= S_VA;
          end else begin
            state <= S_TLW;
          end
        end
        S_TLW: begin
          if (qt >= t_rdata) begin
            prev  <= KW'(n - 9'd1);
            kind  <= K_ONE;
            klast <= 2'd0;
            c     <= '0;
            k     <= '0;
            acc   <= '0;
            state <= S_VA;
          end else begin
            first <= '0;
            count <= n;
            state <= S_SP;
          end
        end
        // upper-bound search
        S_SP: begin
          if (count == 9'd0) begin
            if (first < 9'd1) begin
              next <= KW'(1);
              prev <= '0;
            end else if (first > n - 9'd1) begin
              next <= KW'(n - 9'd1);
              prev <= KW'(n - 9'd2);
            end else begin
              next <= first[KW-1:0];
              prev <= KW'(first - 9'd1);
            end
            state <= S_NA;
          end else begin
            state <= S_SW;
          end
        end
        S_SW: begin
          if (!(qt < t_rdata)) begin
            first <= probe + 9'd1;
            count <= count - step - 9'd1;
          end else begin
            count <= step;
          end
          state <= S_SP;
        end
        S_NA: state <= S_NW;
        S_NW: begin
          tn    <= t_rdata;
          state <= S_PW;
        end
        S_PW: begin
          c   <= '0;
          k   <= '0;
          acc <= '0;
          if (tn <= t_rdata) begin
            err   <= 1'b1;
            state <= S_OUT;
          end else begin
            d <= tn - t_rdata;
            case (mode)
              kfsi_pkg::MODE_STEP: begin
                kind  <= K_ONE;
                klast <= 2'd0;
              end
              kfsi_pkg::MODE_CUBIC: begin
                kind  <= K_CUB;
                klast <= 2'd3;
              end
              default: begin
                kind  <= K_LIN;
                klast <= 2'd1;
              end
            endcase
            if (num >= tn - t_rdata) begin
              u <= kfsi_pkg::ONE;
              state <= (mode == kfsi_pkg::MODE_CUBIC) ? S_M2 : S_VA;
            end else begin
              rem   <= num;
              u     <= '0;
              dcnt  <= '0;
              state <= S_DIV;
            end
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          rem  <= div_ge ? 32'(rem2 - {1'b0, d}) : rem2[31:0];
          u    <= {u[UW-2:0], div_ge};
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            state <= (mode == kfsi_pkg::MODE_CUBIC) ? S_M2 : S_VA;
          end
        end
        // cubic basis on the shared multiplier
        S_M2:  state <= S_M2R;
        S_M2R: begin
          u2    <= prod[F+UW-1:F];
          state <= S_M3;
        end
        S_M3:  state <= S_M3R;
        S_M3R: begin
          u3    <= prod[F+UW-1:F];
          state <= S_H;
        end
        S_H: begin
          h00   <= 20'sd2 * eu3 - 20'sd3 * eu2 + eone;
          h10   <= eu3 - 20'sd2 * eu2 + eu;
          h01   <= 20'sd3 * eu2 - 20'sd2 * eu3;
          h11   <= eu3 - eu2;
          state <= S_MW0;
        end
        S_MW0:  state <= S_MW0R;
        S_MW0R: begin
          w10   <= sat_w(prod);
          state <= S_MW1;
        end
        S_MW1:  state <= S_MW1R;
        S_MW1R: begin
          w11   <= sat_w(prod);
          state <= S_VA;
        end
        // weighted value terms
        S_VA: state <= S_VM;
        S_VM: state <= S_VS;
        S_VS: begin
          acc <= acc + prod[63:0];
          k   <= k + 2'd1;
          state <= (k == klast) ? S_OUT : S_VA;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            comp_index   <= c;
            sample_value <= err ? 32'sd0 : res_val;
            status       <= err;
            last         <= err || (3'(c) == cc - 3'd1);
            if (err || 3'(c) == cc - 3'd1) begin
              state <= S_IDLE;
            end else begin
              c     <= c + 2'd1;
              k     <= '0;
              acc   <= '0;
              state <= S_VA;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/kfsi_ram.sv -----
// kfsi_ram: generic single-port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module kfsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // registered read; a write to the same address returns the old word (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// testbench: self-checking bench for keyframe_sampler_interpolator_top
// depends on kfsi_pkg and the RTL; tracks the key table and predicts each sample
`timescale 1ns / 1ps

module testbench;
  import kfsi_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE_CYC  = 130;
  localparam int HOLD_CYC    = 300;
  localparam int SLOTS       = 3;

  typedef struct packed {
    logic [1:0]         ci;
    logic signed [31:0] val;
    logic               lst;
    logic               st;
  } sample_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [7:0] key_index = '0;
  logic [1:0] slot = '0;
  logic [1:0] component = '0;
  logic [31:0] load_word = '0;
  logic [31:0] query_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] comp_index;
  logic signed [31:0] sample_value;
  logic last;
  logic status;

  // shadow of the block's table and registers
  logic [31:0] key_time [MAX_KEYS];
  logic [31:0] key_val [MAX_KEYS*SLOTS*MAX_COMPONENTS];
  logic [1:0] sh_mode;
  logic [8:0] sh_keys;
  logic [2:0] sh_comps;

  sample_res_t pending_samples [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit no_gaps = 1'b0;

  keyframe_sampler_interpolator_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .key_index(key_index), .slot(slot),
    .component(component), .load_word(load_word), .query_time(query_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .comp_index(comp_index), .sample_value(sample_value),
    .last(last), .status(status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint stored_val(int k, int s, int c);
    return longint'($signed(key_val[(k*SLOTS + s)*MAX_COMPONENTS + c]));
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // expected results of one sample at time t
  task automatic predict_sample(input logic [31:0] t);
    int n, cc, first, count, stp, probe, nx, pv, ck, c;
    logic [1:0] md;
    bit cub;
    int vs;
    longint one, d, num, u, u2, u3, h00, h10, h01, h11, w10, w11, v, s;
    sample_res_t r;
    one = longint'(1) << FRAC_BITS;
    n = (sh_keys == 0) ? 1 : int'(sh_keys);
    if (n > MAX_KEYS) n = MAX_KEYS;
    cc = (sh_comps == 0) ? 1 : int'(sh_comps);
    if (cc > MAX_COMPONENTS) cc = MAX_COMPONENTS;
    md = (sh_mode == 2'd3) ? MODE_LINEAR : sh_mode;
    cub = (md == MODE_CUBIC);
    vs = cub ? 1 : 0;
    ck = -1;
    nx = 0;
    if (n == 1 || t <= key_time[0]) ck = 0;
    else if (t >= key_time[n-1]) ck = n - 1;
    else begin
      // upper-bound search
      first = 0;
      count = n;
      while (count > 0) begin
        stp = count / 2;
        probe = first + stp;
        if (!(t < key_time[probe])) begin
          first = probe + 1;
          count -= stp + 1;
        end else begin
          count = stp;
        end
      end
      nx = first;
      if (nx < 1) nx = 1;
      if (nx > n - 1) nx = n - 1;
    end
    // end clamps
    if (ck >= 0) begin
      for (c = 0; c < cc; c++) begin
        r.ci = c[1:0];
        r.val = 32'(stored_val(ck, vs, c));
        r.lst = (c == cc - 1);
        r.st = 1'b0;
        pending_samples.push_back(r);
      end
      return;
    end
    pv = nx - 1;
    if (key_time[nx] <= key_time[pv]) begin
      r.ci = '0; r.val = '0; r.lst = 1'b1; r.st = 1'b1;
      pending_samples.push_back(r);
      return;
    end
    d = longint'({32'd0, key_time[nx]}) - longint'({32'd0, key_time[pv]});
    num = longint'({32'd0, t}) - longint'({32'd0, key_time[pv]});
    if (num < 0) num = 0;
    u = (num <<< FRAC_BITS) / d;
    if (u > one) u = one;
    u2 = (u * u) >>> FRAC_BITS;
    u3 = (u2 * u) >>> FRAC_BITS;
    h00 = 2*u3 - 3*u2 + one;
    h10 = u3 - 2*u2 + u;
    h01 = 3*u2 - 2*u3;
    h11 = u3 - u2;
    w10 = clip((h10 * d) >>> FRAC_BITS, -(longint'(1) << 30), longint'(1) << 30);
    w11 = clip((h11 * d) >>> FRAC_BITS, -(longint'(1) << 30), longint'(1) << 30);
    for (c = 0; c < cc; c++) begin
      if (md == MODE_STEP) v = stored_val(pv, 0, c);
      else if (cub) begin
        s = h00 * stored_val(pv, 1, c) + w10 * stored_val(pv, 2, c)
          + h01 * stored_val(nx, 1, c) + w11 * stored_val(nx, 0, c);
        v = s >>> FRAC_BITS;
      end else begin
        s = stored_val(pv, 0, c) * (one - u) + stored_val(nx, 0, c) * u;
        v = s >>> FRAC_BITS;
      end
      v = clip(v, -64'sd2147483648, 64'sd2147483647);
      r.ci = c[1:0];
      r.val = 32'(v);
      r.lst = (c == cc - 1);
      r.st = 1'b0;
      pending_samples.push_back(r);
    end
  endtask

  // offer one item, wait for acceptance, then update the shadow
  task automatic send_item(input logic [1:0] rq, input logic [7:0] ki, input logic [1:0] sl,
                           input logic [1:0] co, input logic [31:0] wd, input logic [31:0] qt);
    int g;
    in_valid <= 1'b1;
    req_type <= rq;
    key_index <= ki;
    slot <= sl;
    component <= co;
    load_word <= wd;
    query_time <= qt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (rq)
      REQ_LOAD_TIME: key_time[ki] = wd;
      REQ_LOAD_VALUE: if (sl != SLOT_NONE) key_val[(ki*SLOTS + sl)*MAX_COMPONENTS + co] = wd;
      REQ_SAMPLE: predict_sample(qt);
      default: ;
    endcase
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic sample_at(input logic [31:0] t);
    send_item(REQ_SAMPLE, 8'($urandom), 2'($urandom), 2'($urandom), $urandom, t);
  endtask

  // stop offering, drain all results, and let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 9'(val);
    @(posedge clk);
    case (idx)
      CFG_INTERP_MODE: sh_mode = val[1:0];
      CFG_KEY_COUNT: sh_keys = val[8:0];
      CFG_COMPONENT_COUNT: sh_comps = val[2:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned md, input int unsigned kc, input int unsigned cc);
    settle();
    write_reg(CFG_INTERP_MODE, md);
    write_reg(CFG_KEY_COUNT, kc);
    write_reg(CFG_COMPONENT_COUNT, cc);
  endtask

  // a time between the keys k and k+1, just around the table's ends, or fully random
  function automatic logic [31:0] pick_time(int n);
    int k;
    int r;
    logic [31:0] lo, hi;
    r = $urandom_range(0, 99);
    if (n < 2) n = 2;
    if (r < 5) return $urandom;
    if (r < 10) return key_time[0] - 32'($urandom_range(0, 5000));
    if (r < 15) return key_time[n-1] + 32'($urandom_range(0, 5000));
    k = $urandom_range(0, n - 2);
    lo = key_time[k];
    hi = key_time[k+1];
    if (hi <= lo) return lo;
    return lo + 32'($urandom_range(0, hi - lo));
  endfunction

  // fill every time and value word, plus items that must be ignored
  task automatic test_table_load();
    logic [31:0] tm;
    int k, s, c;
    logic [31:0] w;
    tm = 32'($urandom_range(0, 1000));
    for (k = 0; k < MAX_KEYS; k++) begin
      send_item(REQ_LOAD_TIME, 8'(k), 2'($urandom), 2'($urandom), tm, $urandom);
      tm = tm + 32'($urandom_range(1, 1 << 22));
    end
    for (k = 0; k < MAX_KEYS; k++)
      for (s = 0; s < SLOTS; s++)
        for (c = 0; c < MAX_COMPONENTS; c++) begin
          w = $urandom;
          if (k == 1) w = 32'h7FFF_FFFF;
          if (k == 2) w = 32'h8000_0000;
          send_item(REQ_LOAD_VALUE, 8'(k), 2'(s), 2'(c), w, $urandom);
        end
    // slot three and request code three change nothing
    send_item(REQ_LOAD_VALUE, 8'd5, SLOT_NONE, 2'd1, 32'hDEAD_BEEF, 32'd0);
    send_item(2'd3, 8'd5, SLOT_VAL, 2'd0, 32'h1234_5678, 32'hFFFF_FFFF);
  endtask

  // samples at and beyond the first and the last key
  task automatic test_end_clamps();
    set_regs(MODE_LINEAR, MAX_KEYS, MAX_COMPONENTS);
    sample_at(32'd0);
    sample_at(key_time[0]);
    sample_at(32'hFFFF_FFFF);
    sample_at(key_time[MAX_KEYS-1]);
    set_regs(MODE_CUBIC, 8, 2);
    sample_at(32'd0);
    sample_at(32'hFFFF_FFFF);
  endtask

  // every mode, including the unused code that acts as linear
  task automatic test_modes();
    int m;
    for (m = 0; m < 4; m++) begin
      set_regs(m, 16, 4);
      sample_at(key_time[1] + (key_time[2] - key_time[1]) / 2);
      sample_at(key_time[3]);
      sample_at(key_time[5] + 32'd1);
      sample_at(key_time[9] - 32'd1);
    end
  endtask

  // zero and excess key and component counts
  task automatic test_counts();
    set_regs(MODE_LINEAR, 0, 0);
    sample_at(key_time[3]);
    set_regs(MODE_CUBIC, 1, 7);
    sample_at(key_time[3]);
    set_regs(MODE_STEP, 2, 5);
    sample_at(key_time[0] + 32'd7);
    set_regs(MODE_LINEAR, 511, 1);
    sample_at(key_time[200] + 32'd3);
    sample_at(32'hFFFF_FFFF);
    set_regs(MODE_CUBIC, 300, 4);
    sample_at(key_time[128] + 32'd100);
  endtask

  // receiver stalls long while samples keep coming
  task automatic test_backpressure();
    int i;
    set_regs(MODE_CUBIC, 64, 4);
    hold_req = 1'b1;
    for (i = 0; i < 10; i++) sample_at(pick_time(64));
  endtask

  // random phases: mostly samples inside the table, some loads and noise
  task automatic test_random();
    int ph, i, r, n;
    for (ph = 0; ph < 4; ph++) begin
      r = $urandom_range(0, 4);
      n = (r == 0) ? MAX_KEYS : (r == 1) ? 2 : $urandom_range(1, 300);
      set_regs($urandom_range(0, 3), n, $urandom_range(0, 7));
      no_gaps = (ph == 2);
      for (i = 0; i < 55; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) sample_at(pick_time(n > MAX_KEYS ? MAX_KEYS : n));
        else if (r < 80)
          send_item(REQ_LOAD_TIME, 8'($urandom), 2'($urandom), 2'($urandom),
                    $urandom, $urandom);
        else if (r < 95)
          send_item(REQ_LOAD_VALUE, 8'($urandom), 2'($urandom), 2'($urandom),
                    $urandom, $urandom);
        else
          send_item(2'd3, 8'($urandom), 2'($urandom), 2'($urandom), $urandom, $urandom);
      end
      no_gaps = 1'b0;
    end
  endtask

  task automatic report(input string what, input longint exp_v, input longint got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // receiver: random ready pattern plus one long hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    sample_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report("unexpected result", 0, sample_value);
      end else begin
        e = pending_samples.pop_front();
        if (comp_index !== e.ci) report("comp_index", e.ci, comp_index);
        if (sample_value !== e.val) report("sample_value", e.val, sample_value);
        if (last !== e.lst) report("last", e.lst, last);
        if (status !== e.st) report("status", e.st, status);
      end
    end
  end

  // watchdog on cycles without any accepted item or taken result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    sh_mode = MODE_LINEAR;
    sh_keys = 9'd1;
    sh_comps = 3'd3;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_end_clamps();
    test_modes();
    test_counts();
    test_backpressure();
    test_random();
    settle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
